### hw/rtl/mu8dh_pkg.sv
// ----------------------------------------------------------------------------
// mu8dh_pkg: shared types and constants
// Result beat layout, decoder phase codes and fixed sizes for the
// modified UTF-8 decode/hash core.
// ----------------------------------------------------------------------------
package mu8dh_pkg;

    localparam logic [15:0] MAX_CHARS   = 16'hFFFF;
    localparam logic [15:0] MAX_DROPPED = 16'hFFFF;

    // Result queue: room for two beats of one byte plus slack.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    typedef enum logic {
        KIND_CHAR    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] char_value;
        logic [15:0] char_count;
        logic        all_latin1;
        logic [31:0] string_hash;
        logic        status;
        logic [15:0] bad_groups;
        logic        last_result;
    } t_result;

endpackage

### hw/rtl/modified_utf8_decode_hash_core.sv
// ----------------------------------------------------------------------------
// modified_utf8_decode_hash_core: modified UTF-8 decoder with string hash
// Decodes one-, two- and three-byte groups into 16-bit characters, keeps a
// running hash, count and Latin-1 flag, and closes each buffer with a summary.
// ----------------------------------------------------------------------------
// Output: result beats are held in a registered queue and leave from its head.
// Throughput: one byte per cycle while two queue slots are free. A byte that
//   yields two beats (a character completed on the last byte, plus the summary)
//   is drained one beat at a time; the 4-entry result queue absorbs that, input
//   stalls while fewer than two slots are free (three or more beats waiting).
// Reset: synchronous active-low; decoder state returns to lead phase with
//   hash, counts cleared and Latin-1 flag set; the result queue empties.
module modified_utf8_decode_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [15:0] o_char_value,
    output logic [15:0] o_char_count,
    output logic        o_all_latin1,
    output logic [31:0] o_string_hash,
    output logic        o_status,
    output logic [15:0] o_bad_groups,
    output logic        o_last_result
);
    import mu8dh_pkg::*;

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    t_phase      r_phase,     n_phase;
    logic [7:0]  r_first,     n_first;
    logic [7:0]  r_second,    n_second;
    logic [15:0] r_dec_count, n_dec_count;
    logic        r_latin1,    n_latin1;
    logic [31:0] r_hash,      n_hash;
    logic [15:0] r_dropped,   n_dropped;

    // ------------------------------------------------------------------
    // Result queue (flops; one beat popped per cycle while i_ready, up to two pushed)
    // ------------------------------------------------------------------
    t_result          r_queue [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0]   r_count,  n_count;

    logic        in_beat;
    logic        out_beat;
    logic        have_char;
    logic        open_group;
    logic [15:0] char_val;
    logic [31:0] hash_upd;
    logic [15:0] count_upd;
    logic        latin1_upd;
    logic [15:0] dropped_upd;
    t_result     char_res;
    t_result     sum_res;
    t_result     wr_res0;
    t_result     wr_res1;
    logic [1:0]  push_n;
    t_result     head;

    // Never take a byte unless two slots are free.
    assign o_ready  = (r_count <= QCW'(QDEPTH - 2));
    assign in_beat  = i_valid && o_ready;
    assign o_valid  = (r_count != '0);
    assign out_beat = o_valid && i_ready;

    // ------------------------------------------------------------------
    // Group decode: at most one character per byte.
    // ------------------------------------------------------------------
    always_comb begin
        have_char   = 1'b0;
        open_group  = 1'b0;
        char_val    = '0;
        n_phase     = PH_LEAD;
        n_first     = r_first;
        n_second    = r_second;
        latin1_upd  = r_latin1;
        dropped_upd = r_dropped;
        case (r_phase)
            PH_SECOND: begin
                if (!r_first[5] && (i_byte_value[7:6] == 2'b10)) begin
                    // two-byte character
                    have_char = 1'b1;
                    char_val  = {5'd0, r_first[4:0], i_byte_value[5:0]};
                    if (char_val[15:8] != 8'd0) begin
                        latin1_upd = 1'b0;
                    end
                end else if (i_last_byte) begin
                    open_group = 1'b1;
                end else begin
                    n_second = i_byte_value;
                    n_phase  = PH_THIRD;
                end
            end
            PH_THIRD: begin
                if (!r_first[4] && (r_second[7:6] == 2'b10)
                        && (i_byte_value[7:6] == 2'b10)) begin
                    have_char  = 1'b1;
                    char_val   = {r_first[3:0], r_second[5:0], i_byte_value[5:0]};
                    latin1_upd = 1'b0;
                end else if (r_dropped < MAX_DROPPED) begin
                    // bad triplet: dropped, counted
                    dropped_upd = r_dropped + 16'd1;
                end
            end
            default: begin
                // lead phase (unused code falls here too)
                if (!i_byte_value[7]) begin
                    have_char = 1'b1;
                    char_val  = {8'd0, i_byte_value};
                end else if (i_last_byte) begin
                    open_group = 1'b1;
                end else begin
                    n_first = i_byte_value;
                    n_phase = PH_SECOND;
                end
            end
        endcase
    end

    // hash*31 + c as shift-subtract-add
    always_comb begin
        hash_upd  = r_hash;
        count_upd = r_dec_count;
        if (have_char) begin
            hash_upd = {r_hash[26:0], 5'd0} - r_hash + {16'd0, char_val};
            if (r_dec_count < MAX_CHARS) begin
                count_upd = r_dec_count + 16'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result beats for this byte
    // ------------------------------------------------------------------
    always_comb begin
        char_res.kind        = KIND_CHAR;
        char_res.char_value  = char_val;
        char_res.char_count  = count_upd;
        char_res.all_latin1  = latin1_upd;
        char_res.string_hash = hash_upd;
        char_res.status      = 1'b0;
        char_res.bad_groups  = dropped_upd;
        char_res.last_result = !i_last_byte;

        sum_res              = char_res;
        sum_res.kind         = KIND_SUMMARY;
        sum_res.char_value   = '0;
        sum_res.status       = open_group;
        sum_res.last_result  = 1'b1;

        wr_res0 = have_char ? char_res : sum_res;
        wr_res1 = sum_res;
        push_n  = {1'b0, have_char} + {1'b0, i_last_byte};
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_dec_count = r_dec_count;
        n_latin1    = r_latin1;
        n_hash      = r_hash;
        n_dropped   = r_dropped;
        if (in_beat) begin
            n_dec_count = count_upd;
            n_latin1    = latin1_upd;
            n_hash      = hash_upd;
            n_dropped   = dropped_upd;
        end

        n_wr_ptr = r_wr_ptr + (in_beat ? QAW'(push_n) : QAW'(0));
        n_rd_ptr = r_rd_ptr + (out_beat ? QAW'(1) : QAW'(0));
        n_count  = r_count + (in_beat ? QCW'(push_n) : QCW'(0))
                   - (out_beat ? QCW'(1) : QCW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_first     <= '0;
            r_second    <= '0;
            r_dec_count <= '0;
            r_latin1    <= 1'b1;
            r_hash      <= '0;
            r_dropped   <= '0;
        end else if (in_beat) begin
            if (i_last_byte) begin
                // buffer done: back to reset values
                r_phase     <= PH_LEAD;
                r_first     <= '0;
                r_second    <= '0;
                r_dec_count <= '0;
                r_latin1    <= 1'b1;
                r_hash      <= '0;
                r_dropped   <= '0;
            end else begin
                r_phase     <= n_phase;
                r_first     <= n_first;
                r_second    <= n_second;
                r_dec_count <= n_dec_count;
                r_latin1    <= n_latin1;
                r_hash      <= n_hash;
                r_dropped   <= n_dropped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_beat && (push_n != 2'd0)) begin
            r_queue[r_wr_ptr] <= wr_res0;
        end
        if (in_beat && (push_n == 2'd2)) begin
            r_queue[r_wr_ptr + QAW'(1)] <= wr_res1;
        end
    end

    // ------------------------------------------------------------------
    // Output head
    // ------------------------------------------------------------------
    assign head          = r_queue[r_rd_ptr];
    assign o_result_kind = head.kind;
    assign o_char_value  = head.char_value;
    assign o_char_count  = head.char_count;
    assign o_all_latin1  = head.all_latin1;
    assign o_string_hash = head.string_hash;
    assign o_status      = head.status;
    assign o_bad_groups  = head.bad_groups;
    assign o_last_result = head.last_result;

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) || (r_count == QCW'(QDEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill count");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_last_byte |=> (r_phase == PH_LEAD) && (r_hash == '0)
            && (r_dec_count == '0) && r_latin1)
        else $error("buffer end did not clear decoder state");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && !i_last_byte |=> (r_dec_count >= $past(r_dec_count))
            && (r_dropped >= $past(r_dropped)))
        else $error("running count went backward");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (push_n == 2'd2) |=> r_count >= QCW'(1))
        else $error("two-beat byte left queue empty");
`endif

endmodule

### bench/modified_utf8_decode_hash_core_test.sv
// ----------------------------------------------------------------------------
// modified_utf8_decode_hash_core_test: self-checking bench for the decoder
// Feeds modified UTF-8 buffers through the byte channel under random gaps
// and output stalls. A scoreboard replays each accepted byte through its own
// decoder and hash model and checks every result beat field by field.
// ----------------------------------------------------------------------------
module modified_utf8_decode_hash_core_test;

    import mu8dh_pkg::*;

    // Generous cap for the slowest correct run: about 1300 bytes, two beats
    // each at worst, under idling.
    localparam int unsigned CYCLE_LIMIT  = 100_000;
    localparam int unsigned RANDOM_BYTES = 1250;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PRINT_CAP    = 40;

    // ------------------------------------------------------------------------
    // Scoreboard: decoder state replica plus the queue of pending beats
    // ------------------------------------------------------------------------
    class decode_scoreboard;
        t_result     pending[$];
        int unsigned errors;

        t_phase      phase;
        logic [7:0]  lead_octet;
        logic [7:0]  mid_octet;
        logic [15:0] nchars;
        logic        latin1;
        logic [31:0] hash;
        logic [15:0] ndropped;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase      = PH_LEAD;
            lead_octet = 8'h00;
            mid_octet  = 8'h00;
            nchars     = 16'h0000;
            latin1     = 1'b1;
            hash       = 32'h0000_0000;
            ndropped   = 16'h0000;
        endfunction

        function void take_char(logic [15:0] c);
            hash = hash * 32'd31 + {16'h0000, c};
            if (nchars != MAX_CHARS) nchars++;
        endfunction

        function void push_beat(t_kind kind, logic [15:0] c, logic open);
            t_result r;
            r.kind        = kind;
            r.char_value  = c;
            r.char_count  = nchars;
            r.all_latin1  = latin1;
            r.string_hash = hash;
            r.status      = open;
            r.bad_groups  = ndropped;
            r.last_result = 1'b0;
            pending.push_back(r);
        endfunction

        // One accepted byte: advance the decoder and queue its beats.
        function void note_byte(logic [7:0] b, logic last);
            int unsigned prior_size;
            logic        open;
            logic [15:0] c;
            prior_size = pending.size();
            open       = 1'b0;
            case (phase)
                PH_SECOND: begin
                    if (!lead_octet[5] && b[7:6] == 2'b10) begin
                        c = {5'd0, lead_octet[4:0], b[5:0]};
                        if (c >= 16'd256) latin1 = 1'b0;
                        take_char(c);
                        push_beat(KIND_CHAR, c, 1'b0);
                        phase = PH_LEAD;
                    end else if (last) begin
                        open  = 1'b1;
                        phase = PH_LEAD;
                    end else begin
                        mid_octet = b;
                        phase     = PH_THIRD;
                    end
                end
                PH_THIRD: begin
                    if (!lead_octet[4] && mid_octet[7:6] == 2'b10 && b[7:6] == 2'b10) begin
                        c = {lead_octet[3:0], mid_octet[5:0], b[5:0]};
                        latin1 = 1'b0;
                        take_char(c);
                        push_beat(KIND_CHAR, c, 1'b0);
                    end else if (ndropped != MAX_DROPPED) begin
                        ndropped++;
                    end
                    phase = PH_LEAD;
                end
                default: begin
                    // lead phase; an unknown phase falls back here too
                    phase = PH_LEAD;
                    if (!b[7]) begin
                        take_char({8'h00, b});
                        push_beat(KIND_CHAR, {8'h00, b}, 1'b0);
                    end else if (last) begin
                        open = 1'b1;
                    end else begin
                        lead_octet = b;
                        phase      = PH_SECOND;
                    end
                end
            endcase
            if (last) begin
                push_beat(KIND_SUMMARY, 16'h0000, open);
                restart();
            end
            if (pending.size() > prior_size) pending[pending.size() - 1].last_result = 1'b1;
        endfunction

        task report_mismatch(string msg);
            if (errors < PRINT_CAP) $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending (kind %0d char %h)",
                                          got.kind, got.char_value));
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.char_value !== want.char_value)
                report_mismatch($sformatf("char_value %h, want %h",
                                          got.char_value, want.char_value));
            if (got.char_count !== want.char_count)
                report_mismatch($sformatf("char_count %0d, want %0d",
                                          got.char_count, want.char_count));
            if (got.all_latin1 !== want.all_latin1)
                report_mismatch($sformatf("all_latin1 %b, want %b",
                                          got.all_latin1, want.all_latin1));
            if (got.string_hash !== want.string_hash)
                report_mismatch($sformatf("string_hash %h, want %h",
                                          got.string_hash, want.string_hash));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %b, want %b", got.status, want.status));
            if (got.bad_groups !== want.bad_groups)
                report_mismatch($sformatf("bad_groups %0d, want %0d",
                                          got.bad_groups, want.bad_groups));
            if (got.last_result !== want.last_result)
                report_mismatch($sformatf("last_result %b, want %b",
                                          got.last_result, want.last_result));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_byte_value;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready;
    logic        o_result_kind;
    logic [15:0] o_char_value;
    logic [15:0] o_char_count;
    logic        o_all_latin1;
    logic [31:0] o_string_hash;
    logic        o_status;
    logic [15:0] o_bad_groups;
    logic        o_last_result;

    modified_utf8_decode_hash_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_byte_value  (i_byte_value),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_char_value  (o_char_value),
        .o_char_count  (o_char_count),
        .o_all_latin1  (o_all_latin1),
        .o_string_hash (o_string_hash),
        .o_status      (o_status),
        .o_bad_groups  (o_bad_groups),
        .o_last_result (o_last_result)
    );

    decode_scoreboard sb;
    bit               steady;       // 1: neither side idles
    int unsigned      cycles;
    logic [7:0]       octets[$];

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_byte_value = 8'h00;
        i_last_byte  = 1'b0;
        i_ready      = 1'b0;
        steady       = 1'b0;
        cycles       = 0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hang or a lost beat ends here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("modified_utf8_decode_hash_core regression: fail");
            $finish;
        end
    end

    // Result side: ready drops about 35% of cycles unless in a steady stretch.
    always @(negedge i_clk) begin
        if (steady) i_ready = 1'b1;
        else        i_ready = ($urandom_range(99) >= 35);
    end

    // Monitor: both channels sampled at the rising edge, values settled
    // since the falling edge. Accepted bytes feed the model, accepted beats
    // are checked against the oldest pending one.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.kind        = t_kind'(o_result_kind);
                got.char_value  = o_char_value;
                got.char_count  = o_char_count;
                got.all_latin1  = o_all_latin1;
                got.string_hash = o_string_hash;
                got.status      = o_status;
                got.bad_groups  = o_bad_groups;
                got.last_result = o_last_result;
                sb.check_result(got);
            end
            if (i_valid && o_ready) sb.note_byte(i_byte_value, i_last_byte);
        end
    end

    // ------------------------------------------------------------------------
    // Byte driver
    // ------------------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!steady) begin
            while ($urandom_range(99) < 35) begin
                i_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid      = 1'b1;
        i_byte_value = b;
        i_last_byte  = last;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_buffer(input logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
    endtask

    function automatic logic [7:0] cont_octet();
        return 8'(8'h80 | $urandom_range(63));
    endfunction

    // One well-formed character. narrow keeps it inside Latin-1.
    function automatic void add_char(ref logic [7:0] q[$], input bit narrow);
        int unsigned pick;
        pick = narrow ? $urandom_range(1) : $urandom_range(2);
        case (pick)
            0: q.push_back(8'($urandom_range(127)));
            1: begin
                // duplet lead: bit 7 set, bit 5 clear (0x80..0x9F pass too)
                if (narrow) q.push_back(8'(8'h80 | ($urandom_range(1) << 6) | $urandom_range(3)));
                else        q.push_back(8'(8'h80 | ($urandom_range(1) << 6) | $urandom_range(31)));
                q.push_back(cont_octet());
            end
            default: begin
                // triplet lead: bit 5 set, bit 4 clear
                q.push_back(8'(8'hA0 | ($urandom_range(1) << 6) | $urandom_range(15)));
                q.push_back(cont_octet());
                q.push_back(cont_octet());
            end
        endcase
    endfunction

    // Random buffer: mostly clean text, some noisy or broken, some truncated.
    function automatic void make_buffer(ref logic [7:0] q[$]);
        int unsigned nchars;
        bit          narrow;
        bit          clean;
        int unsigned r;
        q.delete();
        nchars = $urandom_range(10, 1);
        narrow = ($urandom_range(9) < 3);
        clean  = ($urandom_range(99) < 75);
        for (int k = 0; k < nchars; k++) begin
            r = $urandom_range(99);
            if (clean ? (r < 5) : (r < 40)) begin
                q.push_back(8'($urandom_range(255)));
            end else if (!clean && r < 60) begin
                // opened group followed by a non-continuation byte
                q.push_back(8'(8'h80 | $urandom_range(127)));
                if ($urandom_range(1)) q.push_back(8'($urandom_range(127)));
                else                   q.push_back(8'(8'hC0 | $urandom_range(63)));
            end else begin
                add_char(q, narrow);
            end
        end
        // buffer cut off inside a group
        if ($urandom_range(9) == 0) q.push_back(8'(8'h80 | $urandom_range(127)));
        else if ($urandom_range(9) == 0) begin
            q.push_back(8'(8'h80 | $urandom_range(31)));
            q.push_back(8'($urandom_range(255)));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned sent;
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed buffers.
        octets = {8'h00};                       // char and summary from one byte
        send_buffer(octets);
        octets = {8'h7F, 8'h41};
        send_buffer(octets);
        octets = {8'hC2, 8'h80, 8'hC3, 8'hBF};  // duplets below 256 keep Latin-1
        send_buffer(octets);
        octets = {8'h80, 8'h80, 8'hDF, 8'hBF};  // 0x80 lead accepted; 0x7FF clears flag
        send_buffer(octets);
        octets = {8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF};
        send_buffer(octets);
        octets = {8'hF0, 8'h80, 8'h80, 8'hE0, 8'h41, 8'h80, 8'hE0, 8'h80, 8'h41};
        send_buffer(octets);                    // bad triplets, the last one on last byte
        octets = {8'hC2};                       // lead on last byte: open
        send_buffer(octets);
        octets = {8'hC2, 8'h41};                // failing second byte on last: open
        send_buffer(octets);
        octets = {8'hFF, 8'hFF, 8'hFF};
        send_buffer(octets);

        // Random buffers; a steady window sits in the middle.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            steady = (sent >= 500 && sent < 700);
            make_buffer(octets);
            send_buffer(octets);
            sent += octets.size();
        end
        steady  = 1'b0;
        i_valid = 1'b0;

        // Drain, then keep watching for any stray beat.
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d result beats never arrived", sb.pending.size()));

        if (sb.errors == 0) begin
            $display("modified_utf8_decode_hash_core regression: pass");
        end else begin
            $display("modified_utf8_decode_hash_core regression: fail");
        end
        $finish;
    end

endmodule

### modified_utf8_decode_hash_core.f
hw/rtl/mu8dh_pkg.sv
hw/rtl/modified_utf8_decode_hash_core.sv
bench/modified_utf8_decode_hash_core_test.sv
